FILE: design/bep_pkg.sv
// Shared types and constants for the breakpoint envelope player.
// Used by bep_div, bep_ctrl, bep_datapath and breakpoint_envelope_player.
package bep_pkg;

  localparam int DEF_MAX_LANES    = 8;
  localparam int DEF_MAX_POINTS   = 256;
  localparam int LANE_FIELD_LANES = 8;
  localparam int BEAT_W           = 32;
  localparam int LEVEL_W          = 24;
  localparam int MAG_W            = LEVEL_W + 1;
  localparam int PROD_W           = MAG_W + BEAT_W;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_HEADER  = 2'd1,
    OP_POINT   = 2'd2,
    OP_DISABLE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    LVL_FIRST,
    LVL_LAST,
    LVL_PREV,
    LVL_INTERP
  } lvl_sel_t;

  typedef enum logic [1:0] {
    ADR_FIRST,
    ADR_LAST,
    ADR_IDX
  } addr_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIRST,
    ST_LAST,
    ST_MOD,
    ST_CLASS,
    ST_SRD,
    ST_SCMP,
    ST_DIVGO,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [2:0]          lane;
    logic [7:0]          point_index;
    logic [31:0]         beat;
    logic signed [23:0]  level;
    logic [31:0]         target_node;
    logic [15:0]         target_param;
    logic [8:0]          point_count;
    logic                enable;
    logic                playing;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          out_lane;
    logic [31:0]         out_node;
    logic [15:0]         out_param;
    logic signed [23:0]  out_level;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic      apply_write;
    logic      tick_start;
    logic      lane_next;
    logic      rd_en;
    addr_sel_t addr_sel;
    logic      save_first;
    logic      save_last;
    logic      div_start;
    logic      div_mod;
    logic      b_from_mod;
    logic      b_from_play;
    logic      srch_init;
    logic      srch_adv;
    logic      mul;
    logic      emit;
    lvl_sel_t  lvl_sel;
  } cmd_t;

  typedef struct packed {
    logic tick_req;
    logic lanes_done;
    logic lane_act;
    logic last_nz;
    logic b_le_first;
    logic b_ge_last;
    logic hit;
    logic seg_zero;
    logic idx_end;
    logic div_done;
  } sts_t;

endpackage

FILE: design/bep_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bep_pkg for the operand widths.
module bep_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bep_pkg::PROD_W-1:0] dividend,
  input  logic [bep_pkg::BEAT_W-1:0] divisor,
  output logic                      done,
  output logic [bep_pkg::PROD_W-1:0] quotient,
  output logic [bep_pkg::BEAT_W-1:0] remainder
);
  import bep_pkg::*;

  localparam int CW = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] q_r;
  logic [BEAT_W-1:0] rem_r;
  logic [BEAT_W-1:0] d_r;
  logic [CW-1:0]     cnt_r;
  logic              run_r;
  logic              done_r;
  logic [BEAT_W:0]   sh;
  logic              fits;

  always_comb begin
    sh   = {rem_r, q_r[PROD_W-1]};
    fits = (sh >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(PROD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (run_r) begin
      q_r   <= {q_r[PROD_W-2:0], fits};
      rem_r <= fits ? BEAT_W'(sh - {1'b0, d_r}) : BEAT_W'(sh);
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

FILE: design/bep_ctrl.sv
// Sequencer for the envelope player: walks the lanes, the wrap, the segment
// search and the interpolation. Depends on bep_pkg.
module bep_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bep_pkg::sts_t sts,
  output bep_pkg::cmd_t cmd,
  output logic          busy
);
  import bep_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start && sts.tick_req) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.lanes_done) state_nxt = ST_IDLE;
        else if (sts.lane_act) state_nxt = ST_FIRST;
      end
      ST_FIRST: state_nxt = ST_LAST;
      ST_LAST:  state_nxt = sts.last_nz ? ST_MOD : ST_CLASS;
      ST_MOD:   if (sts.div_done) state_nxt = ST_CLASS;
      ST_CLASS: begin
        if (sts.b_le_first || sts.b_ge_last) state_nxt = ST_SCAN;
        else state_nxt = ST_SRD;
      end
      ST_SRD:   state_nxt = ST_SCMP;
      ST_SCMP: begin
        if (sts.hit) state_nxt = sts.seg_zero ? ST_SCAN : ST_DIVGO;
        else state_nxt = sts.idx_end ? ST_SCAN : ST_SRD;
      end
      ST_DIVGO: state_nxt = ST_DIV;
      ST_DIV:   if (sts.div_done) state_nxt = ST_SCAN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = ADR_FIRST;
    cmd.lvl_sel  = LVL_FIRST;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (sts.tick_req) cmd.tick_start = 1'b1;
          else cmd.apply_write = 1'b1;
        end
      end
      ST_SCAN: begin
        if (!sts.lanes_done) begin
          if (sts.lane_act) cmd.rd_en = 1'b1;
          else cmd.lane_next = 1'b1;
        end
      end
      ST_FIRST: begin
        cmd.save_first = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.addr_sel   = ADR_LAST;
      end
      ST_LAST: begin
        cmd.save_last = 1'b1;
        if (sts.last_nz) begin
          cmd.div_start = 1'b1;
          cmd.div_mod   = 1'b1;
        end else begin
          cmd.b_from_play = 1'b1;
        end
      end
      ST_MOD: cmd.b_from_mod = sts.div_done;
      ST_CLASS: begin
        if (sts.b_le_first) begin
          cmd.emit = 1'b1;
        end else if (sts.b_ge_last) begin
          cmd.emit    = 1'b1;
          cmd.lvl_sel = LVL_LAST;
        end else begin
          cmd.srch_init = 1'b1;
        end
      end
      ST_SRD: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADR_IDX;
      end
      ST_SCMP: begin
        if (sts.hit) begin
          if (sts.seg_zero) begin
            cmd.emit    = 1'b1;
            cmd.lvl_sel = LVL_PREV;
          end else begin
            cmd.mul = 1'b1;
          end
        end else if (sts.idx_end) begin
          cmd.emit    = 1'b1;
          cmd.lvl_sel = LVL_LAST;
        end else begin
          cmd.srch_adv = 1'b1;
        end
      end
      ST_DIVGO: cmd.div_start = 1'b1;
      ST_DIV: begin
        cmd.emit    = sts.div_done;
        cmd.lvl_sel = LVL_INTERP;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> busy) else $error("result emitted while idle");
  a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_start |=> state_r == ST_SCAN) else $error("tick did not start scan");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done) else $error("divider finished too early");

endmodule

FILE: design/bep_datapath.sv
// Lane headers, breakpoint memories, wrap and interpolation arithmetic and
// the result register. Depends on bep_pkg and bep_div.
module bep_datapath #(
  parameter int MAX_LANES  = bep_pkg::DEF_MAX_LANES,
  parameter int MAX_POINTS = bep_pkg::DEF_MAX_POINTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bep_pkg::in_item_t in_data,
  input  bep_pkg::cmd_t     cmd,
  output bep_pkg::sts_t     sts,
  output logic              out_valid,
  output bep_pkg::out_item_t out_data
);
  import bep_pkg::*;

  localparam int NSCAN  = (MAX_LANES < LANE_FIELD_LANES) ? MAX_LANES : LANE_FIELD_LANES;
  localparam int LI_W   = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int LC_W   = $clog2(NSCAN + 1);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DEPTH  = MAX_LANES * MAX_POINTS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [BEAT_W-1:0]  beat_mem  [DEPTH];
  logic [LEVEL_W-1:0] level_mem [DEPTH];

  logic [31:0]       node_r  [MAX_LANES];
  logic [15:0]       param_r [MAX_LANES];
  logic [CNT_W-1:0]  cnt_r   [MAX_LANES];
  logic [MAX_LANES-1:0] en_r;

  logic [LC_W-1:0]    lane_r;
  logic [CNT_W-1:0]   idx_r;
  logic [BEAT_W-1:0]  play_r, b_r;
  logic [BEAT_W-1:0]  rd_beat_r, first_beat_r, last_beat_r, prev_beat_r;
  logic [LEVEL_W-1:0] rd_level_r, first_level_r, last_level_r, prev_level_r;
  logic [PROD_W-1:0]  prod_r;
  logic [BEAT_W-1:0]  span_r;
  logic               neg_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic [LI_W-1:0]    li;
  logic [CNT_W-1:0]   cur_cnt;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [NSCAN-1:0]   act;
  logic               later;
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]   mag;
  logic               div_done;
  logic [PROD_W-1:0]  quot;
  logic [BEAT_W-1:0]  rem;
  logic [PROD_W-1:0]  dvd;
  logic [BEAT_W-1:0]  dvs;
  logic signed [MAG_W:0] interp;
  logic [LEVEL_W-1:0] lvl;
  logic               lane_ok, pt_ok;

  assign li      = LI_W'(lane_r);
  assign cur_cnt = cnt_r[li];
  assign lane_ok = 32'(in_data.lane) < 32'(MAX_LANES);
  assign pt_ok   = 32'(in_data.point_index) < 32'(MAX_POINTS);
  assign wr_addr = ADDR_W'(in_data.lane) * ADDR_W'(MAX_POINTS) + ADDR_W'(in_data.point_index);

  always_comb begin
    rd_addr = ADDR_W'(li) * ADDR_W'(MAX_POINTS);
    case (cmd.addr_sel)
      ADR_LAST: rd_addr = rd_addr + ADDR_W'(cur_cnt - 1'b1);
      ADR_IDX:  rd_addr = rd_addr + ADDR_W'(idx_r);
      default:  ;
    endcase
  end

  // A lane takes part when it is enabled and holds at least one point.
  always_comb begin
    later = 1'b0;
    for (int l = 0; l < NSCAN; l++) begin
      act[l] = en_r[l] && (cnt_r[l] != '0);
      if ((LC_W + 1)'(l) > (LC_W + 1)'(lane_r) && act[l]) later = 1'b1;
    end
  end

  always_comb begin
    diff = $signed({rd_level_r[LEVEL_W-1], rd_level_r})
         - $signed({prev_level_r[LEVEL_W-1], prev_level_r});
    mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  end

  always_comb begin
    interp = $signed({{2{prev_level_r[LEVEL_W-1]}}, prev_level_r});
    if (neg_r) interp = interp - $signed({1'b0, quot[MAG_W-1:0]});
    else interp = interp + $signed({1'b0, quot[MAG_W-1:0]});
    case (cmd.lvl_sel)
      LVL_LAST:   lvl = last_level_r;
      LVL_PREV:   lvl = prev_level_r;
      LVL_INTERP: lvl = LEVEL_W'(interp);
      default:    lvl = first_level_r;
    endcase
  end

  always_comb begin
    sts            = '0;
    sts.tick_req   = (op_t'(in_data.operation) == OP_TICK) && in_data.playing;
    sts.lanes_done = (lane_r >= LC_W'(NSCAN));
    sts.lane_act   = !sts.lanes_done && en_r[li] && (cur_cnt != '0);
    sts.last_nz    = (rd_beat_r != '0);
    sts.b_le_first = (b_r <= first_beat_r);
    sts.b_ge_last  = (b_r >= last_beat_r);
    sts.hit        = (b_r >= prev_beat_r) && (b_r <= rd_beat_r);
    sts.seg_zero   = (rd_beat_r == prev_beat_r);
    sts.idx_end    = ((CNT_W + 1)'(idx_r) + 1'b1) >= (CNT_W + 1)'(cur_cnt);
    sts.div_done   = div_done;
  end

  assign dvd = cmd.div_mod ? PROD_W'(play_r) : prod_r;
  assign dvs = cmd.div_mod ? rd_beat_r : span_r;

  bep_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.apply_write && op_t'(in_data.operation) == OP_POINT && lane_ok && pt_ok) begin
      beat_mem[wr_addr]  <= in_data.beat;
      level_mem[wr_addr] <= in_data.level;
    end
    if (cmd.rd_en) begin
      rd_beat_r  <= beat_mem[rd_addr];
      rd_level_r <= level_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
      for (int l = 0; l < MAX_LANES; l++) begin
        node_r[l]  <= '0;
        param_r[l] <= '0;
        cnt_r[l]   <= '0;
      end
    end else if (cmd.apply_write) begin
      if (op_t'(in_data.operation) == OP_DISABLE) begin
        en_r <= '0;
      end else if (op_t'(in_data.operation) == OP_HEADER && lane_ok) begin
        node_r[LI_W'(in_data.lane)]  <= in_data.target_node;
        param_r[LI_W'(in_data.lane)] <= in_data.target_param;
        cnt_r[LI_W'(in_data.lane)]   <= (32'(in_data.point_count) > 32'(MAX_POINTS)) ?
                                        CNT_W'(MAX_POINTS) : CNT_W'(in_data.point_count);
        en_r[LI_W'(in_data.lane)]    <= in_data.enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.tick_start) lane_r <= '0;
      else if (cmd.lane_next || cmd.emit) lane_r <= lane_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) play_r <= in_data.beat;
    if (cmd.save_first) begin
      first_beat_r  <= rd_beat_r;
      first_level_r <= rd_level_r;
    end
    if (cmd.save_last) begin
      last_beat_r  <= rd_beat_r;
      last_level_r <= rd_level_r;
    end
    if (cmd.b_from_play) b_r <= play_r;
    else if (cmd.b_from_mod) b_r <= rem;
    if (cmd.srch_init) begin
      idx_r        <= CNT_W'(1);
      prev_beat_r  <= first_beat_r;
      prev_level_r <= first_level_r;
    end else if (cmd.srch_adv) begin
      idx_r        <= idx_r + 1'b1;
      prev_beat_r  <= rd_beat_r;
      prev_level_r <= rd_level_r;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(mag * (b_r - prev_beat_r));
      span_r <= rd_beat_r - prev_beat_r;
      neg_r  <= diff[MAG_W-1];
    end
    if (cmd.emit) begin
      out_r.out_lane  <= 3'(lane_r);
      out_r.out_node  <= node_r[li];
      out_r.out_param <= param_r[li];
      out_r.out_level <= lvl;
      out_r.last      <= !later;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: design/breakpoint_envelope_player.sv
// Top level of the breakpoint envelope player.
// Depends on bep_pkg, bep_ctrl and bep_datapath.
//
// Input words arrive on in_data and are taken on a clock edge where start is
// high and busy is low. Header writes, breakpoint writes and disable-all take
// effect at that edge and busy stays low. A tick with playing set raises
// busy while the lanes are walked in order; each enabled lane with points
// gives one result word on out_data, marked by out_valid for one cycle, with
// last set on the final word of the tick. The receiver cannot stall.
// Per lane the block reads the first and last breakpoints, wraps the playhead
// with a divide when the last beat is nonzero, clamps it to the end levels or
// else searches the breakpoints in order, and divides for the interpolation.
// Skipped lanes are stepped over. The shared bit-serial divider and the single
// read port of the breakpoint memories serialise this work.
// Reset clears lane headers and enables; breakpoint memories hold no reset
// value and must be written before use.
module breakpoint_envelope_player #(
  parameter int MAX_LANES  = bep_pkg::DEF_MAX_LANES,
  parameter int MAX_POINTS = bep_pkg::DEF_MAX_POINTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bep_pkg::in_item_t  in_data,
  output logic               out_valid,
  output bep_pkg::out_item_t out_data
);
  import bep_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bep_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bep_datapath #(
    .MAX_LANES  (MAX_LANES),
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back result words");
  a_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result word after tick finished");
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (op_t'(in_data.operation) != OP_TICK)) |=> !busy)
    else $error("write operation held the block busy");

endmodule

FILE: sim/bep_checker.sv
// Checker for the breakpoint envelope player: keeps its own lane state,
// predicts the result words of each tick and compares them. Depends on bep_pkg.
`timescale 1ns / 1ps
module bep_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  bep_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  bep_pkg::out_item_t out_data,
  output int                 errors,
  output int                 outstanding
);
  import bep_pkg::*;

  localparam int LANES  = 8;
  localparam int POINTS = 256;

  logic [31:0]        point_beat  [LANES][POINTS];
  logic signed [23:0] point_level [LANES][POINTS];
  logic [31:0]        lane_node   [LANES];
  logic [15:0]        lane_param  [LANES];
  logic [8:0]         lane_count  [LANES];
  logic               lane_on     [LANES];

  out_item_t expected_words [$];

  // Level of one lane at the given playhead.
  function automatic logic signed [23:0] envelope_level(int l, logic [31:0] playhead);
    int unsigned        cnt;
    logic [31:0]        pos, first_b, last_b, ab, pb;
    longint             av, pv, diff;
    longint unsigned    mag, q;
    cnt     = lane_count[l];
    first_b = point_beat[l][0];
    last_b  = point_beat[l][cnt-1];
    pos     = playhead;
    if (last_b != 0) pos = pos % last_b;
    if (pos <= first_b) return point_level[l][0];
    if (pos >= last_b) return point_level[l][cnt-1];
    for (int i = 1; i < cnt; i++) begin
      ab = point_beat[l][i-1];
      pb = point_beat[l][i];
      if (pos >= ab && pos <= pb) begin
        if (pb == ab) return point_level[l][i-1];
        av   = point_level[l][i-1];
        pv   = point_level[l][i];
        diff = pv - av;
        mag  = (diff < 0) ? -diff : diff;
        q    = mag * longint'(pos - ab) / longint'(pb - ab);
        return (diff < 0) ? 24'(av - longint'(q)) : 24'(av + longint'(q));
      end
    end
    return point_level[l][cnt-1];
  endfunction

  task automatic apply_word(in_item_t w);
    out_item_t r;
    int        n;
    case (op_t'(w.operation))
      OP_HEADER: begin
        lane_node[w.lane]  = w.target_node;
        lane_param[w.lane] = w.target_param;
        lane_count[w.lane] = (w.point_count > POINTS) ? 9'(POINTS) : w.point_count;
        lane_on[w.lane]    = w.enable;
      end
      OP_POINT: begin
        point_beat[w.lane][w.point_index]  = w.beat;
        point_level[w.lane][w.point_index] = w.level;
      end
      OP_DISABLE: begin
        for (int l = 0; l < LANES; l++) lane_on[l] = 1'b0;
      end
      default: begin
        if (w.playing) begin
          n = 0;
          for (int l = 0; l < LANES; l++) begin
            if (lane_on[l] && lane_count[l] != 0) begin
              r.out_lane  = 3'(l);
              r.out_node  = lane_node[l];
              r.out_param = lane_param[l];
              r.out_level = envelope_level(l, w.beat);
              r.last      = 1'b0;
              expected_words = {expected_words, r};
              n++;
            end
          end
          if (n > 0) expected_words[expected_words.size()-1].last = 1'b1;
        end
      end
    endcase
  endtask

  task automatic report(string what, longint exp_v, longint got_v);
    errors++;
    if (errors <= 10)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, exp_v, got_v);
  endtask

  initial begin
    errors = 0;
    outstanding = 0;
    for (int l = 0; l < LANES; l++) begin
      lane_node[l]  = '0;
      lane_param[l] = '0;
      lane_count[l] = '0;
      lane_on[l]    = 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (start && !busy) apply_word(in_data);
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          report("unexpected word, lane", 0, out_data.out_lane);
        end else begin
          e = expected_words.pop_front();
          if (e.out_lane !== out_data.out_lane) report("lane", e.out_lane, out_data.out_lane);
          if (e.out_node !== out_data.out_node) report("node", e.out_node, out_data.out_node);
          if (e.out_param !== out_data.out_param)
            report("param", e.out_param, out_data.out_param);
          if (e.out_level !== out_data.out_level)
            report("level", 24'(e.out_level), 24'(out_data.out_level));
          if (e.last !== out_data.last) report("last", e.last, out_data.last);
        end
      end
      outstanding <= expected_words.size();
    end
  end
endmodule

FILE: sim/tb_breakpoint_envelope_player.sv
// Testbench top for the breakpoint envelope player: drives directed and random
// command words and gives the verdict. Depends on bep_pkg and bep_checker.
`timescale 1ns / 1ps
module tb_breakpoint_envelope_player;
  import bep_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;
  int        errors, outstanding;
  int        words_sent = 0;
  logic      idle_allowed = 1'b1;
  logic      point_written [8][256];

  always #5 clk = ~clk;

  breakpoint_envelope_player dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  bep_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .errors(errors), .outstanding(outstanding)
  );

  // Number of points written contiguously from slot zero.
  function automatic int written_prefix(int l);
    int n;
    n = 0;
    while (n < 256 && point_written[l][n]) n++;
    return n;
  endfunction

  function automatic in_item_t noise_word();
    in_item_t w;
    w = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    return w;
  endfunction

  // Holds the word on the port until it is taken; start stays high afterwards unless a random idle gap follows.
  task automatic send(in_item_t w);
    int gap;
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    if (op_t'(w.operation) == OP_POINT) point_written[w.lane][w.point_index] = 1'b1;
    gap = 0;
    if (idle_allowed && $urandom_range(0, 9) >= 6)
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_point(int l, int idx, logic [31:0] b, logic [23:0] lv);
    in_item_t w;
    w = noise_word();
    w.operation   = OP_POINT;
    w.lane        = 3'(l);
    w.point_index = 8'(idx);
    w.beat        = b;
    w.level       = lv;
    send(w);
  endtask

  task automatic put_header(int l, logic [31:0] node, logic [15:0] param,
                            logic [8:0] cnt, logic en);
    in_item_t w;
    w = noise_word();
    w.operation    = OP_HEADER;
    w.lane         = 3'(l);
    w.target_node  = node;
    w.target_param = param;
    w.point_count  = cnt;
    w.enable       = en;
    send(w);
  endtask

  task automatic put_tick(logic play, logic [31:0] head);
    in_item_t w;
    w = noise_word();
    w.operation = OP_TICK;
    w.playing   = play;
    w.beat      = head;
    send(w);
  endtask

  task automatic put_disable();
    in_item_t w;
    w = noise_word();
    w.operation = OP_DISABLE;
    send(w);
  endtask

  // Writes a sorted table of n points, sometimes with repeated beats, then enables it.
  task automatic build_lane(int l, int n);
    logic [31:0] b;
    b = $urandom_range(0, 16'h4000);
    for (int i = 0; i < n; i++) begin
      put_point(l, i, b, 24'($urandom));
      case ($urandom_range(0, 9))
        0:       b = b;
        1:       b = b + $urandom_range(1, 8);
        default: b = b + $urandom_range(1, 16'h8000);
      endcase
    end
    put_header(l, $urandom, 16'($urandom), 9'(n), 1'b1);
  endtask

  initial begin
    int r, l, pre;
    logic en, paused;
    paused = 1'b0;
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 256; j++) point_written[i][j] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    put_tick(1'b1, 32'h0001_0000);
    put_tick(1'b0, 32'hFFFF_FFFF);
    put_point(0, 0, 32'h0000_0000, 24'h80_0000);
    put_point(0, 1, 32'h0001_0000, 24'h7F_FFFF);
    put_point(0, 2, 32'h0002_0000, 24'h00_0000);
    put_header(0, 32'hFFFF_FFFF, 16'hFFFF, 9'd3, 1'b1);
    put_point(7, 0, 32'h0000_0000, 24'h00_0005);
    put_header(7, 32'h0000_0000, 16'h0000, 9'd1, 1'b1);
    put_header(1, 32'h1234_5678, 16'h00AA, 9'd0, 1'b1);
    put_header(2, 32'hDEAD_BEEF, 16'h5555, 9'h1FF, 1'b0);
    put_point(5, 255, 32'hFFFF_FFFF, 24'h7F_FFFF);
    put_tick(1'b1, 32'h0000_0000);
    put_tick(1'b1, 32'h0000_8000);
    put_tick(1'b1, 32'h0001_8000);
    put_tick(1'b1, 32'h0002_0000);
    put_tick(1'b1, 32'hFFFF_FFFF);
    put_tick(1'b1, 32'h0003_4000);
    put_disable();
    put_tick(1'b1, 32'h0000_4000);
    put_header(0, 32'h0000_0001, 16'h0001, 9'd3, 1'b1);
    put_tick(1'b1, 32'h0000_C000);
    put_header(2, 32'h0000_0002, 16'h0002, 9'd300, 1'b0);

    // Random part: mostly well-formed lane set-ups and ticks, plus stray writes.
    while (words_sent < 280) begin
      if (words_sent % 40 == 0) idle_allowed = ($urandom_range(0, 3) != 0);
      if (!paused && words_sent >= 150) begin
        // Let every outstanding result drain before sending more.
        paused = 1'b1;
        start <= 1'b0;
        @(posedge clk);
        while (busy || outstanding != 0) @(posedge clk);
        @(posedge clk);
      end
      r = $urandom_range(0, 99);
      l = $urandom_range(0, 7);
      if (r < 8) begin
        build_lane(l, ($urandom_range(0, 19) == 0) ? $urandom_range(13, 48)
                                                    : $urandom_range(1, 12));
      end else if (r < 48) begin
        put_tick($urandom_range(0, 9) != 0,
                 $urandom_range(0, 1) ? $urandom_range(0, 32'h8_0000) : $urandom);
      end else if (r < 62) begin
        put_point(l, $urandom_range(0, 255), $urandom, 24'($urandom));
      end else if (r < 78) begin
        pre = written_prefix(l);
        en  = 1'($urandom_range(0, 1));
        if (en) put_header(l, $urandom, 16'($urandom), 9'($urandom_range(0, pre)), 1'b1);
        else    put_header(l, $urandom, 16'($urandom), 9'($urandom), 1'b0);
      end else if (r < 83) begin
        put_disable();
      end else begin
        put_tick(1'b0, $urandom);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (busy || outstanding != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
